[hw/rtl/life_automaton_generation_macros.svh]
// Assertion helpers for the RTL that carries checks.
`ifndef LIFE_AUTOMATON_GENERATION_MACROS_SVH
`define LIFE_AUTOMATON_GENERATION_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LIFEGEN_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LIFEGEN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/lifegen_pkg.sv]
`timescale 1ns / 1ps

package lifegen_pkg;

   // Width of the grid size registers.
   localparam int DIM_W = 7;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_STEP  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // Controller to datapath.
   typedef struct packed {
      logic accept;
      logic cell_rd;
      logic cell_wr;
      logic step_run;
      logic load_rsp;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic req_inside;
      logic step_done;
   } sts_type;

endpackage

[hw/rtl/lifegen_csr.sv]
`timescale 1ns / 1ps

module lifegen_csr #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [2:0]                      paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready,
   output logic [lifegen_pkg::DIM_W-1:0]   eff_rows,
   output logic [lifegen_pkg::DIM_W-1:0]   eff_cols
);

   localparam logic       REG_ROWS = 1'b0;
   localparam logic       REG_COLS = 1'b1;
   localparam logic [8:0] ROW_LIM  = 9'(MAX_ROWS);
   localparam logic [8:0] COL_LIM  = 9'(MAX_COLS);

   logic [lifegen_pkg::DIM_W-1:0] rows_ff;
   logic [lifegen_pkg::DIM_W-1:0] cols_ff;
   logic                          wr_en;

   // Zero acts as one, anything above the grid acts as the grid size.
   function automatic logic [lifegen_pkg::DIM_W-1:0] clamp_dim(
      input logic [lifegen_pkg::DIM_W-1:0] v,
      input logic [8:0]                    lim
   );
      logic [lifegen_pkg::DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = lifegen_pkg::DIM_W'(1);
      end else if ({2'b00, v} > lim) begin
         r = lim[lifegen_pkg::DIM_W-1:0];
      end
      return r;
   endfunction

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= lifegen_pkg::DIM_W'(64);
         cols_ff <= lifegen_pkg::DIM_W'(64);
      end else if (wr_en) begin
         if (paddr[2] == REG_ROWS) begin
            rows_ff <= pwdata[lifegen_pkg::DIM_W-1:0];
         end else begin
            cols_ff <= pwdata[lifegen_pkg::DIM_W-1:0];
         end
      end
   end

   always_comb begin
      prdata = '0;
      case (paddr[2])
         REG_ROWS: prdata[lifegen_pkg::DIM_W-1:0] = rows_ff;
         REG_COLS: prdata[lifegen_pkg::DIM_W-1:0] = cols_ff;
         default:  prdata = '0;
      endcase
   end

   assign eff_rows = clamp_dim(rows_ff, ROW_LIM);
   assign eff_cols = clamp_dim(cols_ff, COL_LIM);

endmodule

[hw/rtl/lifegen_dpath.sv]
`timescale 1ns / 1ps

module lifegen_dpath #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lifegen_pkg::cmd_type          cmd,
   output lifegen_pkg::sts_type          sts,
   input  logic [1:0]                    req_opcode,
   input  logic [5:0]                    req_cell_row,
   input  logic [5:0]                    req_cell_col,
   input  logic                          req_cell_alive,
   input  logic [lifegen_pkg::DIM_W-1:0] eff_rows,
   input  logic [lifegen_pkg::DIM_W-1:0] eff_cols,
   output logic                          rsp_read_alive,
   output logic                          rsp_out_of_range
);

   localparam int RW    = $clog2(MAX_ROWS);
   localparam int CW    = $clog2(MAX_COLS);
   localparam int CNT_W = lifegen_pkg::DIM_W + 1;

   // One row of cells per word.
   logic [MAX_COLS-1:0] grid_mem [0:MAX_ROWS-1];

   logic [MAX_ROWS-1:0] row_vld_ff;
   logic [MAX_COLS-1:0] mem_q_ff;
   logic                mem_vld_ff;
   logic                rd_live_ff;
   logic [CNT_W-1:0]    cnt_ff;

   logic [1:0]          op_ff;
   logic [RW-1:0]       row_ff;
   logic [CW-1:0]       col_ff;
   logic                alive_ff;
   logic                inside_ff;
   logic                read_alive_ff;
   logic                oor_ff;

   logic [MAX_COLS-1:0] prev_ff;
   logic [MAX_COLS-1:0] cur_ff;
   logic [MAX_COLS-1:0] nxt_ff;

   logic [7:0]          req_row_ext;
   logic [7:0]          req_col_ext;
   logic                req_inside;
   logic [CNT_W-1:0]    rows_ext;
   logic [CNT_W-1:0]    wr_cnt;
   logic                step_rd;
   logic                step_shift;
   logic                step_wr;
   logic                mem_re;
   logic                mem_we;
   logic [RW-1:0]       rd_addr;
   logic [RW-1:0]       wr_addr;
   logic [MAX_COLS-1:0] wr_data;
   logic [MAX_COLS-1:0] rd_data;
   logic [MAX_COLS-1:0] shift_data;
   logic [MAX_COLS-1:0] cell_wdata;
   logic [MAX_COLS-1:0] col_mask;
   logic [MAX_COLS-1:0] new_row;
   logic [MAX_COLS+1:0] prev_p;
   logic [MAX_COLS+1:0] cur_p;
   logic [MAX_COLS+1:0] nxt_p;
   logic [3:0]          nbr;

   assign req_row_ext = {2'b00, req_cell_row};
   assign req_col_ext = {2'b00, req_cell_col};
   assign req_inside  = ({1'b0, req_cell_row} < eff_rows) &&
                        ({1'b0, req_cell_col} < eff_cols);

   // Sweep schedule: read row c, shift window at c, write row c-3.
   assign rows_ext   = {1'b0, eff_rows};
   assign wr_cnt     = cnt_ff - CNT_W'(3);
   assign step_rd    = cmd.step_run && (cnt_ff < rows_ext);
   assign step_shift = cmd.step_run && (cnt_ff != '0) && (cnt_ff <= rows_ext + CNT_W'(1));
   assign step_wr    = cmd.step_run && (cnt_ff >= CNT_W'(3));

   always_comb begin
      sts.req_inside = req_inside;
      sts.step_done  = cmd.step_run && (cnt_ff == rows_ext + CNT_W'(2));
   end

   // Rows never written since reset read as dead.
   assign rd_data    = mem_vld_ff ? mem_q_ff : '0;
   assign shift_data = rd_live_ff ? rd_data : '0;

   always_comb begin
      cell_wdata         = rd_data;
      cell_wdata[col_ff] = alive_ff;
   end

   assign mem_re  = cmd.cell_rd | step_rd;
   assign mem_we  = step_wr | (cmd.cell_wr && (op_ff == lifegen_pkg::OP_WRITE));
   assign rd_addr = cmd.step_run ? cnt_ff[RW-1:0] : row_ff;
   assign wr_addr = cmd.step_run ? wr_cnt[RW-1:0] : row_ff;
   assign wr_data = cmd.step_run ? new_row : cell_wdata;

   always_comb begin
      for (int j = 0; j < MAX_COLS; j++) begin
         col_mask[j] = (9'(j) < {2'b00, eff_cols});
      end
   end

   // Next generation of the middle row; inactive columns keep their value.
   always_comb begin
      prev_p = {1'b0, prev_ff & col_mask, 1'b0};
      cur_p  = {1'b0, cur_ff & col_mask, 1'b0};
      nxt_p  = {1'b0, nxt_ff & col_mask, 1'b0};
      nbr    = '0;
      for (int j = 0; j < MAX_COLS; j++) begin
         nbr = 4'(prev_p[j]) + 4'(prev_p[j+1]) + 4'(prev_p[j+2]) +
               4'(cur_p[j])  + 4'(cur_p[j+2]) +
               4'(nxt_p[j])  + 4'(nxt_p[j+1]) + 4'(nxt_p[j+2]);
         if (col_mask[j]) begin
            new_row[j] = (nbr == 4'd3) || ((nbr == 4'd2) && cur_ff[j]);
         end else begin
            new_row[j] = cur_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[wr_addr] <= wr_data;
      end
      if (mem_re) begin
         mem_q_ff <= grid_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
         mem_vld_ff <= 1'b0;
         rd_live_ff <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         if (mem_we) begin
            row_vld_ff[wr_addr] <= 1'b1;
         end
         if (mem_re) begin
            mem_vld_ff <= row_vld_ff[rd_addr];
         end
         rd_live_ff <= step_rd;
         if (cmd.accept) begin
            cnt_ff <= '0;
         end else if (cmd.step_run) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff     <= req_opcode;
         row_ff    <= req_row_ext[RW-1:0];
         col_ff    <= req_col_ext[CW-1:0];
         alive_ff  <= req_cell_alive;
         inside_ff <= req_inside;
         prev_ff   <= '0;
         cur_ff    <= '0;
         nxt_ff    <= '0;
      end else if (step_shift) begin
         prev_ff <= cur_ff;
         cur_ff  <= nxt_ff;
         nxt_ff  <= shift_data;
      end
      if (cmd.load_rsp) begin
         read_alive_ff <= (op_ff == lifegen_pkg::OP_READ) && inside_ff && rd_data[col_ff];
         oor_ff        <= ((op_ff == lifegen_pkg::OP_WRITE) ||
                           (op_ff == lifegen_pkg::OP_READ)) && !inside_ff;
      end
   end

   assign rsp_read_alive   = read_alive_ff;
   assign rsp_out_of_range = oor_ff;

endmodule

[hw/rtl/lifegen_ctrl.sv]
`timescale 1ns / 1ps

module lifegen_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_opcode,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lifegen_pkg::cmd_type cmd,
   input  lifegen_pkg::sts_type sts
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_CELL_RD = 3'd1;
   localparam logic [2:0] ST_CELL_OP = 3'd2;
   localparam logic [2:0] ST_STEP    = 3'd3;
   localparam logic [2:0] ST_FINISH  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       accept;
   logic       slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd.accept   = accept;
      cmd.cell_rd  = (state_ff == ST_CELL_RD);
      cmd.cell_wr  = (state_ff == ST_CELL_OP);
      cmd.step_run = (state_ff == ST_STEP);
      cmd.load_rsp = (state_ff == ST_FINISH) && slot_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_opcode == lifegen_pkg::OP_STEP) begin
                  state_in = ST_STEP;
               end else if (((req_opcode == lifegen_pkg::OP_WRITE) ||
                             (req_opcode == lifegen_pkg::OP_READ)) && sts.req_inside) begin
                  state_in = ST_CELL_RD;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_CELL_RD: state_in = ST_CELL_OP;
         ST_CELL_OP: state_in = ST_FINISH;
         ST_STEP: begin
            if (sts.step_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp | (rsp_valid_ff & !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[hw/rtl/life_automaton_generation.sv]
// Cell write / read: the request passes the row-read, cell-operation and finish states, then the
// result is registered; an out-of-range access or unused opcode goes straight to the finish state.
// Step: the sweep runs one row per cycle through the single-read, single-write row memory, then
//   the finish state registers the result. A new item is taken only once the last is back in idle.
// Reset clears the grid at once through per-row valid bits (no clearing pass) and sets
//   both size registers to 64.
`timescale 1ns / 1ps

`include "life_automaton_generation_macros.svh"

module life_automaton_generation #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [5:0]  req_cell_row,
   input  logic [5:0]  req_cell_col,
   input  logic        req_cell_alive,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_read_alive,
   output logic        rsp_out_of_range,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Controller/datapath handshake.
   lifegen_pkg::cmd_type          cmd;
   lifegen_pkg::sts_type          sts;

   // Grid size after clamping to 1..MAX.
   logic [lifegen_pkg::DIM_W-1:0] eff_rows;
   logic [lifegen_pkg::DIM_W-1:0] eff_cols;

   // Size registers; the user must write them only between items (the block does not enforce it),
   // so no guarding against a change in the middle of a sweep.
   lifegen_csr #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (csr_psel),
      .penable  (csr_penable),
      .pwrite   (csr_pwrite),
      .paddr    (csr_paddr),
      .pwdata   (csr_pwdata),
      .prdata   (csr_prdata),
      .pready   (csr_pready),
      .eff_rows (eff_rows),
      .eff_cols (eff_cols)
   );

   // Sequencer: one item at a time; the result register lets the next
   // transfer in proceed while a result still waits on the response side.
   lifegen_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // Row memory, three-row window, per-column neighbor count, result register.
   // A single-cell write is a read-modify-write of its row.
   lifegen_dpath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_opcode       (req_opcode),
      .req_cell_row     (req_cell_row),
      .req_cell_col     (req_cell_col),
      .req_cell_alive   (req_cell_alive),
      .eff_rows         (eff_rows),
      .eff_cols         (eff_cols),
      .rsp_read_alive   (rsp_read_alive),
      .rsp_out_of_range (rsp_out_of_range)
   );

   // A new result never overwrites one that has not been taken.
   `LIFEGEN_ASSERT_SAME(a_load_free, clock, reset, cmd.load_rsp, (!rsp_valid || rsp_ready), "result overwritten")
   // An accepted step transfer starts the sweep on the next cycle.
   `LIFEGEN_ASSERT_NEXT(a_step_start, clock, reset, (req_valid && req_ready && (req_opcode == lifegen_pkg::OP_STEP)), cmd.step_run, "sweep did not start")
   // Sweep completion only occurs while sweeping, and returns to result load.
   `LIFEGEN_ASSERT_NEXT(a_step_end, clock, reset, sts.step_done, (!cmd.step_run && !req_ready), "sweep end out of order")

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

   localparam int MAX_DIM = 64;
   // Opcode value that the block must treat as a no-op.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // Byte addresses of the two size registers.
   localparam logic [2:0] ADDR_ACTIVE_ROWS = 3'd0;
   localparam logic [2:0] ADDR_ACTIVE_COLS = 3'd4;
   // Cycles without any transfer before the run is declared hung.
   localparam int HANG_LIMIT = 3000;
   // Cycles to linger once nothing is outstanding (longest step plus margin).
   localparam int DRAIN_TAIL = 80;
   localparam int RANDOM_ITEMS = 1150;

   typedef struct {
      logic [1:0] opcode;
      logic [5:0] row;
      logic [5:0] col;
      logic       alive;
      int         gap;
      bit         drain;
   } cell_req_type;

   typedef struct packed {
      logic read_alive;
      logic out_of_range;
   } cell_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_opcode = lifegen_pkg::OP_WRITE;
   logic [5:0]  req_cell_row = '0;
   logic [5:0]  req_cell_col = '0;
   logic        req_cell_alive = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_read_alive;
   logic        rsp_out_of_range;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   life_automaton_generation uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_cell_row    (req_cell_row),
      .req_cell_col    (req_cell_col),
      .req_cell_alive  (req_cell_alive),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_alive  (rsp_read_alive),
      .rsp_out_of_range(rsp_out_of_range),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   // Mirror of the block: grid, size registers, and outstanding results.
   bit [MAX_DIM-1:0] grid_model [MAX_DIM];
   logic [6:0]       rows_cfg = 7'd64;
   logic [6:0]       cols_cfg = 7'd64;
   cell_req_type     cell_req_q [$];
   cell_rsp_type     cell_result_q [$];

   // Handshake bookkeeping shared between the edge-triggered blocks.
   bit req_busy = 1'b0;
   bit rsp_taken = 1'b0;
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   int gap_count = 0;
   int stall_count = 0;
   int quiet_cycles = 0;
   int error_count = 0;
   int random_total = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   // Size registers saturate: zero acts as one, anything above the grid acts as the grid.
   function automatic int dim_limit(logic [6:0] v);
      if (v == 7'd0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
   endfunction

   // Apply one transfer to the grid mirror and return the result it must produce.
   function automatic cell_rsp_type life_apply(cell_req_type it);
      int nr, nc, n, rr, cc;
      bit hit;
      bit [MAX_DIM-1:0] next_rows [MAX_DIM];
      cell_rsp_type res;
      nr = dim_limit(rows_cfg);
      nc = dim_limit(cols_cfg);
      hit = (it.row < nr) && (it.col < nc);
      res = '0;
      case (it.opcode)
         lifegen_pkg::OP_WRITE: begin
            if (hit) grid_model[it.row][it.col] = it.alive;
            else res.out_of_range = 1'b1;
         end
         lifegen_pkg::OP_STEP: begin
            // Cells outside the active window keep their value.
            next_rows = grid_model;
            for (int r = 0; r < nr; r++) begin
               for (int c = 0; c < nc; c++) begin
                  n = 0;
                  for (int dr = -1; dr <= 1; dr++) begin
                     for (int dc = -1; dc <= 1; dc++) begin
                        rr = r + dr;
                        cc = c + dc;
                        if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0 && rr < nr && cc < nc)
                           n += grid_model[rr][cc];
                     end
                  end
                  if (n == 3) next_rows[r][c] = 1'b1;
                  else if (n != 2) next_rows[r][c] = 1'b0;
               end
            end
            grid_model = next_rows;
         end
         lifegen_pkg::OP_READ: begin
            if (hit) res.read_alive = grid_model[it.row][it.col];
            else res.out_of_range = 1'b1;
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic queue_cell(input logic [1:0] op, input logic [5:0] row,
                             input logic [5:0] col, input logic alive, input bit drain);
      cell_req_type it;
      it.opcode = op;
      it.row = row;
      it.col = col;
      it.alive = alive;
      it.drain = drain;
      it.gap = req_idle_on ? $urandom_range(0, 7) : 0;
      cell_req_q = {cell_req_q, it};
   endtask

   // One register write: setup cycle, access cycle, done at the edge with pready high.
   task automatic csr_write(input logic [2:0] addr, input logic [6:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= {25'($urandom_range(0, 33554431)), value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
   endtask

   // Resize the grid; only call while the block is idle.
   task automatic set_grid_size(input logic [6:0] rows, input logic [6:0] cols);
      csr_write(ADDR_ACTIVE_ROWS, rows);
      rows_cfg = rows;
      csr_write(ADDR_ACTIVE_COLS, cols);
      cols_cfg = cols;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Hold until every queued transfer has gone in and every result has come out.
   task automatic wait_drained();
      while (cell_req_q.size() != 0 || req_busy || cell_result_q.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [6:0] pick_dim();
      case ($urandom_range(0, 9))
         0: return 7'd0;
         1: return 7'd1;
         2: return 7'd127;
         3: return 7'd64;
         4: return 7'($urandom_range(65, 126));
         default: return 7'($urandom_range(2, 16));
      endcase
   endfunction

   // Request driver: present the head of the queue after its gap, hold it until the transfer.
   always @(negedge clock) begin
      cell_req_type cur;
      if (reset) begin
         req_valid <= 1'b0;
         gap_count = 0;
      end else if (!req_busy) begin
         if (cell_req_q.size() != 0 && gap_count < cell_req_q[0].gap) begin
            gap_count++;
            req_valid <= 1'b0;
         end else if (cell_req_q.size() != 0 &&
                      !(cell_req_q[0].drain && cell_result_q.size() != 0)) begin
            cur = cell_req_q.pop_front();
            req_opcode <= cur.opcode;
            req_cell_row <= cur.row;
            req_cell_col <= cur.col;
            req_cell_alive <= cur.alive;
            req_valid <= 1'b1;
            req_busy = 1'b1;
            gap_count = 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response sink: after each transfer, drop ready for a random stall.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_count = 0;
      end else begin
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            stall_count = rsp_idle_on ? $urandom_range(0, 7) : 0;
         end
         if (stall_count > 0) begin
            stall_count--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Predict on each request transfer; check each response transfer against the oldest
   // prediction.
   always @(posedge clock) begin
      cell_req_type it;
      cell_rsp_type pred;
      cell_rsp_type want;
      if (!reset && req_valid && req_ready) begin
         it.opcode = req_opcode;
         it.row = req_cell_row;
         it.col = req_cell_col;
         it.alive = req_cell_alive;
         pred = life_apply(it);
         cell_result_q = {cell_result_q, pred};
         req_busy = 1'b0;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_taken = 1'b1;
         if (cell_result_q.size() == 0) begin
            $error("unexpected result: read_alive %0d, out_of_range %0d",
                   rsp_read_alive, rsp_out_of_range);
            error_count++;
         end else begin
            want = cell_result_q.pop_front();
            if (rsp_read_alive !== want.read_alive) begin
               $error("read_alive: expected %0d, actual %0d", want.read_alive, rsp_read_alive);
               error_count++;
            end
            if (rsp_out_of_range !== want.out_of_range) begin
               $error("out_of_range: expected %0d, actual %0d",
                      want.out_of_range, rsp_out_of_range);
               error_count++;
            end
         end
      end
   end

   // Watchdog: any transfer on either channel counts as progress.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      int nr, nc;
      logic [6:0] new_rows, new_cols;
      for (int r = 0; r < MAX_DIM; r++) grid_model[r] = '0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: full 64x64 grid straight out of reset. Corners, a no-op, then a
      // step that kills isolated cells; the step holds off until all is drained.
      queue_cell(lifegen_pkg::OP_READ, 6'd5, 6'd5, 1'b0, 1'b0);
      queue_cell(lifegen_pkg::OP_WRITE, 6'd0, 6'd0, 1'b1, 1'b0);
      queue_cell(lifegen_pkg::OP_WRITE, 6'd63, 6'd63, 1'b1, 1'b0);
      queue_cell(lifegen_pkg::OP_WRITE, 6'd0, 6'd63, 1'b1, 1'b0);
      queue_cell(lifegen_pkg::OP_READ, 6'd0, 6'd0, 1'b0, 1'b0);
      queue_cell(lifegen_pkg::OP_READ, 6'd63, 6'd63, 1'b1, 1'b0);
      queue_cell(OP_UNUSED, 6'd63, 6'd63, 1'b1, 1'b0);
      queue_cell(lifegen_pkg::OP_STEP, 6'd63, 6'd0, 1'b1, 1'b1);
      queue_cell(lifegen_pkg::OP_READ, 6'd0, 6'd0, 1'b0, 1'b0);
      queue_cell(lifegen_pkg::OP_READ, 6'd63, 6'd63, 1'b0, 1'b0);
      wait_drained();

      // Zero-sized registers act as a single cell; everything else is out of range.
      set_grid_size(7'd0, 7'd0);
      queue_cell(lifegen_pkg::OP_WRITE, 6'd0, 6'd0, 1'b1, 1'b0);
      queue_cell(lifegen_pkg::OP_WRITE, 6'd1, 6'd0, 1'b1, 1'b0);
      queue_cell(lifegen_pkg::OP_READ, 6'd0, 6'd1, 1'b0, 1'b0);
      queue_cell(lifegen_pkg::OP_STEP, 6'd0, 6'd0, 1'b0, 1'b0);
      queue_cell(lifegen_pkg::OP_READ, 6'd0, 6'd0, 1'b0, 1'b0);
      wait_drained();

      // Three rows, oversized column count: a blinker flips from horizontal to vertical.
      set_grid_size(7'd3, 7'd127);
      queue_cell(lifegen_pkg::OP_WRITE, 6'd1, 6'd10, 1'b1, 1'b0);
      queue_cell(lifegen_pkg::OP_WRITE, 6'd1, 6'd11, 1'b1, 1'b0);
      queue_cell(lifegen_pkg::OP_WRITE, 6'd1, 6'd12, 1'b1, 1'b0);
      queue_cell(lifegen_pkg::OP_STEP, 6'd0, 6'd0, 1'b0, 1'b0);
      queue_cell(lifegen_pkg::OP_READ, 6'd0, 6'd11, 1'b0, 1'b0);
      queue_cell(lifegen_pkg::OP_READ, 6'd2, 6'd11, 1'b0, 1'b0);
      queue_cell(lifegen_pkg::OP_READ, 6'd1, 6'd10, 1'b0, 1'b0);
      queue_cell(lifegen_pkg::OP_READ, 6'd3, 6'd0, 1'b0, 1'b0);
      queue_cell(lifegen_pkg::OP_WRITE, 6'd40, 6'd40, 1'b1, 1'b0);
      wait_drained();

      // Random phases: resize, seed a pattern, run a few generations and sample cells,
      // then sprinkle in raw noise (any opcode, any address).
      while (random_total < RANDOM_ITEMS) begin
         new_rows = pick_dim();
         new_cols = pick_dim();
         set_grid_size(new_rows, new_cols);
         req_idle_on = ($urandom_range(0, 2) != 0);
         rsp_idle_on = ($urandom_range(0, 2) != 0);
         nr = dim_limit(rows_cfg);
         nc = dim_limit(cols_cfg);
         repeat ($urandom_range(3, 24)) begin
            queue_cell(lifegen_pkg::OP_WRITE, 6'($urandom_range(0, nr - 1)),
                       6'($urandom_range(0, nc - 1)),
                       1'($urandom_range(0, 2) != 0), 1'b0);
            random_total++;
         end
         repeat ($urandom_range(1, 4)) begin
            queue_cell(lifegen_pkg::OP_STEP, 6'($urandom), 6'($urandom), 1'($urandom),
                       ($urandom_range(0, 5) == 0));
            random_total++;
            repeat ($urandom_range(2, 8)) begin
               queue_cell(lifegen_pkg::OP_READ, 6'($urandom_range(0, nr - 1)),
                          6'($urandom_range(0, nc - 1)), 1'($urandom), 1'b0);
               random_total++;
            end
         end
         repeat ($urandom_range(0, 6)) begin
            queue_cell(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                       6'($urandom_range(0, 63)), 1'($urandom), 1'b0);
            random_total++;
         end
         wait_drained();
      end

      // Linger past the longest step so a stray result would still be caught.
      repeat (DRAIN_TAIL) @(negedge clock);
      if (error_count == 0 && cell_result_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
